>>> hdl/sot_pkg.sv
// Shared types and constants for the sorted order table.
// Used by every module of the table; no dependencies.
package sot_pkg;

    localparam int TABLE_DEPTH  = 1024;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
    localparam int GROUP_SIZE   = 32;
    localparam int GSEL_W       = $clog2(GROUP_SIZE);
    localparam int NUM_GROUPS   = TABLE_DEPTH / GROUP_SIZE;

    localparam int SP_W         = 8;
    localparam int ITEM_W       = 16;
    localparam int SIZE_W       = 32;
    localparam int QTY_IN_W     = 32;
    localparam int QTY_W        = 31;
    localparam int KEY_W        = SP_W + 2 * ITEM_W;

    localparam int IN_TDATA_W   = 152;
    localparam int OUT_TDATA_W  = 160;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic [SP_W-1:0]   sp;
        logic [ITEM_W-1:0] supp;
        logic [ITEM_W-1:0] stock;
        logic [ITEM_W-1:0] link;
        logic [ITEM_W-1:0] du_items;
        logic [SIZE_W-1:0] du_size;
        logic [QTY_W-1:0]  qty;
    } entry_t;

    typedef struct packed {
        logic cmp_en;
        logic write_en;
    } cell_ctrl_t;

    function automatic logic [KEY_W-1:0] entry_key(input entry_t e);
        return {e.sp, e.supp, e.stock};
    endfunction

endpackage

>>> hdl/sot_cell.sv
// One table cell: holds one entry, compares it with the incoming key
// and shifts from its lower neighbor on insert. Depends on sot_pkg.
module sot_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  sot_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  sot_pkg::entry_t     new_entry,
    input  sot_pkg::entry_t     prev_entry,
    input  logic                prev_after,
    output sot_pkg::entry_t     entry,
    output logic                after
);

    sot_pkg::entry_t entry_reg;
    sot_pkg::entry_t entry_next;
    logic            after_reg;
    logic            after_next;

    always_comb
    begin
        after_next = after_reg;
        if (ctrl.cmp_en)
        begin
            after_next = !occupied ||
                (sot_pkg::entry_key(entry_reg) > sot_pkg::entry_key(new_entry));
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.write_en && after_reg)
        begin
            entry_next = prev_after ? prev_entry : new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_reg <= 1'b0;
        end
        else
        begin
            after_reg <= after_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign after = after_reg;

endmodule

>>> hdl/sot_read_sel.sv
// First level of the read tree: registered select of one entry out of
// a group of cells. Depends on sot_pkg.
module sot_read_sel
(
    input  logic                        clk,
    input  logic                        en,
    input  sot_pkg::entry_t             entries [sot_pkg::GROUP_SIZE],
    input  logic [sot_pkg::GSEL_W-1:0]  sel,
    output sot_pkg::entry_t             entry
);

    sot_pkg::entry_t entry_reg;
    sot_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (en)
        begin
            entry_next = entries[sel];
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> hdl/sorted_order_table_insert.sv
// Top level of the sorted order table: request register, cell chain,
// read tree, sequencer and result register. Depends on sot_pkg, sot_cell
// and sot_read_sel.
//
// The table holds up to 1024 order entries in a row of cells, kept in
// ascending order of (stockpoint, supplier, stock item); an equal key goes
// after the entries already held. Each transaction has three steps:
// accept, compare (every cell compares its key with the new one in
// parallel, and the first read-tree level registers), and write (cells
// past the insert point take their lower neighbor's entry in one shift,
// the new entry lands at the boundary, the result is registered). The
// next transaction is taken while a result waits on the output, and the
// write step waits only for the result register to free. Insert latency
// does not depend on the number of entries held.
module sorted_order_table_insert
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // req_type
    input  logic                              s_tuser,
    // stockpoint_index, supplier_index, stock_index, stock_supplier_index,
    // delivery_unit_items, delivery_unit_size_milli, quantity_milli,
    // read_index, zero pad
    input  logic [sot_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // accepted, table_full, position, entry_count, out_stockpoint,
    // out_supplier, out_stock, out_stock_supplier, out_du_items,
    // out_du_size_milli, out_quantity_milli, zero pad
    output logic [sot_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_WR   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    sot_pkg::entry_t                 req_entry_reg;
    logic                            req_type_reg;
    logic                            req_qty_ok_reg;
    logic [sot_pkg::IDX_W-1:0]       req_index_reg;
    logic [sot_pkg::CNT_W-1:0]       fill_reg;
    logic [sot_pkg::CNT_W-1:0]       fill_next;
    logic                            out_valid_reg;
    logic [sot_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [sot_pkg::OUT_TDATA_W-1:0] out_data_next;

    logic                            in_take;
    logic                            wr_go;
    logic                            is_full;
    logic                            do_insert;
    logic                            read_hit;
    logic [sot_pkg::QTY_IN_W-1:0]    in_qty;
    sot_pkg::entry_t                 in_entry;
    sot_pkg::cell_ctrl_t             ctrl;
    logic [sot_pkg::IDX_W-1:0]       ins_pos;
    logic                            res_accepted;
    logic                            res_full;
    logic [sot_pkg::IDX_W-1:0]       res_pos;
    sot_pkg::entry_t                 res_entry;

    sot_pkg::entry_t cell_entry [sot_pkg::TABLE_DEPTH];
    logic            cell_after [sot_pkg::TABLE_DEPTH];
    logic            boundary   [sot_pkg::TABLE_DEPTH];
    sot_pkg::entry_t grp_entry  [sot_pkg::NUM_GROUPS];

    assign in_take  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_qty   = s_tdata[135:104];

    always_comb
    begin
        in_entry.sp       = s_tdata[7:0];
        in_entry.supp     = s_tdata[23:8];
        in_entry.stock    = s_tdata[39:24];
        in_entry.link     = s_tdata[55:40];
        in_entry.du_items = s_tdata[71:56];
        in_entry.du_size  = s_tdata[103:72];
        in_entry.qty      = in_qty[sot_pkg::QTY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_entry_reg  <= in_entry;
            req_type_reg   <= s_tuser;
            req_qty_ok_reg <= !in_qty[sot_pkg::QTY_IN_W-1] && (in_qty != '0);
            req_index_reg  <= s_tdata[145:136];
        end
    end

    assign wr_go     = (state_reg == ST_WR) && (!out_valid_reg || m_tready);
    assign is_full   = (fill_reg == sot_pkg::CNT_W'(sot_pkg::TABLE_DEPTH));
    assign do_insert = (req_type_reg == sot_pkg::REQ_INSERT) && req_qty_ok_reg && !is_full;
    assign ctrl.cmp_en   = (state_reg == ST_CMP);
    assign ctrl.write_en = wr_go && do_insert;

    genvar gi;
    generate
        for (gi = 0; gi < sot_pkg::TABLE_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                sot_cell u_cell
                (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .occupied   (fill_reg > sot_pkg::CNT_W'(gi)),
                    .new_entry  (req_entry_reg),
                    .prev_entry (req_entry_reg),
                    .prev_after (1'b0),
                    .entry      (cell_entry[gi]),
                    .after      (cell_after[gi])
                );
                assign boundary[gi] = cell_after[gi];
            end
            else
            begin : g_rest
                sot_cell u_cell
                (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .occupied   (fill_reg > sot_pkg::CNT_W'(gi)),
                    .new_entry  (req_entry_reg),
                    .prev_entry (cell_entry[gi-1]),
                    .prev_after (cell_after[gi-1]),
                    .entry      (cell_entry[gi]),
                    .after      (cell_after[gi])
                );
                assign boundary[gi] = cell_after[gi] && !cell_after[gi-1];
            end
        end

        for (gi = 0; gi < sot_pkg::NUM_GROUPS; gi++)
        begin : g_grp
            sot_read_sel u_sel
            (
                .clk     (clk),
                .en      (ctrl.cmp_en),
                .entries (cell_entry[gi*sot_pkg::GROUP_SIZE +: sot_pkg::GROUP_SIZE]),
                .sel     (req_index_reg[sot_pkg::GSEL_W-1:0]),
                .entry   (grp_entry[gi])
            );
        end
    endgenerate

    always_comb
    begin
        ins_pos = '0;
        for (int i = 0; i < sot_pkg::TABLE_DEPTH; i++)
        begin
            if (boundary[i])
            begin
                ins_pos = ins_pos | sot_pkg::IDX_W'(i);
            end
        end
    end

    assign read_hit = ({1'b0, req_index_reg} < fill_reg);

    always_comb
    begin
        res_accepted = 1'b0;
        res_full     = 1'b0;
        res_pos      = '0;
        res_entry    = '0;
        fill_next    = fill_reg;
        if (req_type_reg == sot_pkg::REQ_READ)
        begin
            res_pos = req_index_reg;
            if (read_hit)
            begin
                res_entry = grp_entry[req_index_reg[sot_pkg::IDX_W-1:sot_pkg::GSEL_W]];
            end
        end
        else if (req_qty_ok_reg)
        begin
            if (is_full)
            begin
                res_full = 1'b1;
            end
            else
            begin
                res_accepted = 1'b1;
                res_pos      = ins_pos;
                fill_next    = fill_reg + sot_pkg::CNT_W'(1);
            end
        end
        out_data_next = {2'b00, res_entry.qty, res_entry.du_size, res_entry.du_items,
                         res_entry.link, res_entry.stock, res_entry.supp, res_entry.sp,
                         fill_next, res_pos, res_full, res_accepted};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (wr_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_go)
            begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_go)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= sot_pkg::CNT_W'(sot_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_go && do_insert) |=> (fill_reg == $past(fill_reg) + sot_pkg::CNT_W'(1)))
        else $error("entry count did not advance on insert");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("accepted and table_full both set");

    a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !wr_go |=> $stable(fill_reg))
        else $error("entry count changed outside write step");

endmodule
